/* src/sorted_array_insert_delete_assert.svh */
// Assertion macros for the sorted array block.
`ifndef SORTED_ARRAY_INSERT_DELETE_ASSERT_SVH
`define SORTED_ARRAY_INSERT_DELETE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)
`endif
`endif

/* src/said_pkg.sv */
`timescale 1ns / 1ps
package said_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key_value;
        logic [5:0]         read_index;
    } req_t;

    typedef struct packed {
        logic [6:0]         entry_count;
        logic signed [31:0] read_data;
        logic [1:0]         status;
    } rsp_t;

    typedef logic [3:0] upc_t;

    localparam upc_t U_IDLE      = 4'd0;
    localparam upc_t U_INS_INIT  = 4'd1;
    localparam upc_t U_INS_CHK   = 4'd2;
    localparam upc_t U_INS_SHIFT = 4'd3;
    localparam upc_t U_INS_PLACE = 4'd4;
    localparam upc_t U_DEL_INIT  = 4'd5;
    localparam upc_t U_DEL_STEP  = 4'd6;
    localparam upc_t U_DEL_DONE  = 4'd7;
    localparam upc_t U_RD_ISSUE  = 4'd8;
    localparam upc_t U_RD_TAKE   = 4'd9;
    localparam upc_t U_EMIT      = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INS_INIT,
        OP_INS_SHIFT,
        OP_INS_PLACE,
        OP_DEL_INIT,
        OP_DEL_STEP,
        OP_DEL_DONE,
        OP_RD_ISSUE,
        OP_RD_TAKE,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_FULL,
        C_PZERO,
        C_INS_EXIT,
        C_SCAN_END,
        C_CNT_ZERO,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   jt;
        upc_t   jf;
    } uword_t;

    typedef struct packed {
        logic full;
        logic p_zero;
        logic ins_exit;
        logic scan_end;
        logic cnt_zero;
        logic out_free;
    } dp_flags_t;

    // Control store: op, branch condition, target if true, target if false.
    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        case (addr)
            U_IDLE:      w = '{OP_NOP,       C_DISPATCH, U_IDLE,      U_IDLE};
            U_INS_INIT:  w = '{OP_INS_INIT,  C_FULL,     U_EMIT,      U_INS_CHK};
            U_INS_CHK:   w = '{OP_NOP,       C_PZERO,    U_INS_PLACE, U_INS_SHIFT};
            U_INS_SHIFT: w = '{OP_INS_SHIFT, C_INS_EXIT, U_INS_PLACE, U_INS_SHIFT};
            U_INS_PLACE: w = '{OP_INS_PLACE, C_ALWAYS,   U_EMIT,      U_EMIT};
            U_DEL_INIT:  w = '{OP_DEL_INIT,  C_CNT_ZERO, U_DEL_DONE,  U_DEL_STEP};
            U_DEL_STEP:  w = '{OP_DEL_STEP,  C_SCAN_END, U_DEL_DONE,  U_DEL_STEP};
            U_DEL_DONE:  w = '{OP_DEL_DONE,  C_ALWAYS,   U_EMIT,      U_EMIT};
            U_RD_ISSUE:  w = '{OP_RD_ISSUE,  C_ALWAYS,   U_RD_TAKE,   U_RD_TAKE};
            U_RD_TAKE:   w = '{OP_RD_TAKE,   C_ALWAYS,   U_EMIT,      U_EMIT};
            U_EMIT:      w = '{OP_EMIT,      C_OUT_FREE, U_IDLE,      U_EMIT};
            default:     w = '{OP_NOP,       C_ALWAYS,   U_IDLE,      U_IDLE};
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(input logic [1:0] req_type);
        upc_t t;
        case (req_type)
            REQ_INSERT: t = U_INS_INIT;
            REQ_DELETE: t = U_DEL_INIT;
            REQ_READ:   t = U_RD_ISSUE;
            default:    t = U_EMIT;
        endcase
        return t;
    endfunction

endpackage

/* src/sorted_array_insert_delete.sv */
`timescale 1ns / 1ps
// An insert walks down from the top, moving entries not below the key, until it meets a smaller
// entry or the bottom, then places the key; a full store rejects the insert without a walk.
// A delete scans every entry and compacts; a read fetches one entry; a stalled result waits.
// One request in flight; the next is accepted once idle, entered as the result is registered.
// Rate is set by the walk: one entry read per cycle, one written on insert, kept ones on delete.
// Reset clears the entry count and the result valid flag; store contents stay undefined.
module sorted_array_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  said_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output said_pkg::rsp_t rsp
);

    logic                idle;
    logic                accept;
    said_pkg::dp_op_t    op;
    said_pkg::dp_flags_t flags;

    assign req_stall = !idle;
    assign accept    = req_valid && idle;

    said_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req.req_type),
        .flags    (flags),
        .op       (op),
        .idle     (idle)
    );

    said_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .req       (req),
        .op        (op),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* src/said_seq.sv */
`timescale 1ns / 1ps
module said_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          req_type,
    input  said_pkg::dp_flags_t flags,
    output said_pkg::dp_op_t    op,
    output logic                idle
);

    said_pkg::upc_t   upc_reg;
    said_pkg::upc_t   upc_next;
    said_pkg::uword_t uw;
    logic             take;

    assign uw   = said_pkg::ucode(upc_reg);
    assign op   = uw.op;
    assign idle = (upc_reg == said_pkg::U_IDLE);

    always_comb
    begin
        case (uw.cond)
            said_pkg::C_ALWAYS:   take = 1'b1;
            said_pkg::C_DISPATCH: take = accept;
            said_pkg::C_FULL:     take = flags.full;
            said_pkg::C_PZERO:    take = flags.p_zero;
            said_pkg::C_INS_EXIT: take = flags.ins_exit;
            said_pkg::C_SCAN_END: take = flags.scan_end;
            said_pkg::C_CNT_ZERO: take = flags.cnt_zero;
            said_pkg::C_OUT_FREE: take = flags.out_free;
            default:              take = 1'b1;
        endcase
        if (uw.cond == said_pkg::C_DISPATCH)
        begin
            upc_next = take ? said_pkg::dispatch(req_type) : uw.jf;
        end
        else
        begin
            upc_next = take ? uw.jt : uw.jf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= said_pkg::U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* src/said_dp.sv */
`timescale 1ns / 1ps
`include "sorted_array_insert_delete_assert.svh"
module said_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  said_pkg::req_t      req,
    input  said_pkg::dp_op_t    op,
    output said_pkg::dp_flags_t flags,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output said_pkg::rsp_t      rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 6;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [31:0] store_reg [CAPACITY];

    logic signed [31:0] key_reg, key_next;
    logic [5:0]         idx_reg, idx_next;
    logic [CW-1:0]      p_reg, p_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] res_data_reg, res_data_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    said_pkg::rsp_t     rsp_reg, rsp_next;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;

    logic               less;
    logic               in_range;
    logic               emit;
    logic [XW-1:0]      idx_wide;
    logic [XW-1:0]      cnt_wide;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      p_m1;
    logic [CW-1:0]      p_m2;
    logic [CW+6:0]      cnt_ext;

    assign less     = rd_data_reg < key_reg;
    assign idx_wide = XW'(idx_reg);
    assign cnt_wide = XW'(cnt_reg);
    assign in_range = idx_wide < cnt_wide;
    assign cnt_m1   = cnt_reg - CW'(1);
    assign p_m1     = p_reg - CW'(1);
    assign p_m2     = p_reg - CW'(2);
    assign cnt_ext  = (CW + 7)'(cnt_reg);

    assign flags.full     = cnt_reg >= CAP_C;
    assign flags.p_zero   = (p_reg == '0);
    assign flags.ins_exit = less || (p_reg == CW'(1));
    assign flags.scan_end = (p_reg == cnt_reg);
    assign flags.cnt_zero = (cnt_reg == '0);
    assign flags.out_free = !out_valid_reg || !rsp_stall;

    assign emit      = (op == said_pkg::OP_EMIT) && flags.out_free;
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        key_next      = key_reg;
        idx_next      = idx_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        res_data_next = res_data_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        rsp_next      = rsp_reg;

        if (load)
        begin
            key_next      = req.key_value;
            idx_next      = req.read_index;
            res_data_next = '0;
            status_next   = said_pkg::ST_OK;
        end

        case (op)
            said_pkg::OP_INS_INIT:
            begin
                p_next      = cnt_reg;
                rd_en       = 1'b1;
                rd_addr     = cnt_m1[IW-1:0];
                status_next = flags.full ? said_pkg::ST_FULL : said_pkg::ST_OK;
            end
            said_pkg::OP_INS_SHIFT:
            begin
                // walk down from the top, moving entries not below the key
                if (!less)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg[IW-1:0];
                    mem_wdata = rd_data_reg;
                    p_next    = p_m1;
                    rd_en     = 1'b1;
                    rd_addr   = p_m2[IW-1:0];
                end
            end
            said_pkg::OP_INS_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg[IW-1:0];
                mem_wdata = key_reg;
                cnt_next  = cnt_reg + CW'(1);
            end
            said_pkg::OP_DEL_INIT:
            begin
                p_next  = CW'(1);
                k_next  = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            said_pkg::OP_DEL_STEP:
            begin
                if (rd_data_reg != key_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = k_reg[IW-1:0];
                    mem_wdata = rd_data_reg;
                    k_next    = k_reg + CW'(1);
                end
                rd_en   = 1'b1;
                rd_addr = p_reg[IW-1:0];
                p_next  = p_reg + CW'(1);
            end
            said_pkg::OP_DEL_DONE:
            begin
                cnt_next = k_reg;
            end
            said_pkg::OP_RD_ISSUE:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_wide[IW-1:0];
            end
            said_pkg::OP_RD_TAKE:
            begin
                if (in_range)
                begin
                    res_data_next = rd_data_reg;
                end
                else
                begin
                    status_next = said_pkg::ST_RANGE;
                end
            end
            said_pkg::OP_EMIT:
            begin
                rsp_next.entry_count = cnt_ext[6:0];
                rsp_next.read_data   = res_data_reg;
                rsp_next.status      = status_reg;
            end
            default:
            begin
            end
        endcase

        out_valid_next = (out_valid_reg && rsp_stall) || emit;
        if (!emit)
        begin
            rsp_next = rsp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        res_data_reg <= res_data_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_PROP(a_cnt_bound, clk, rst_n, cnt_reg <= CAP_C, "entry count above capacity")
    `ASSERT_NEXT(a_ins_grow, clk, rst_n, op == said_pkg::OP_INS_PLACE, cnt_reg == $past(cnt_reg) + CW'(1), "insert did not grow count")
    `ASSERT_PROP(a_del_keep, clk, rst_n, (op == said_pkg::OP_DEL_STEP) |-> (k_reg < p_reg), "compaction write overtook scan")

endmodule
